@@ sv/tcf_pkg.sv @@
// Shared types, constants and codes of the timestamp coincidence finder.
`default_nettype none

package tcf_pkg;

  localparam int TS_W     = 63;
  localparam int CNT_W    = 32;
  localparam int CH_W     = 2;
  localparam int NUM_CH   = 3;
  localparam int FOLD_W   = 2;
  localparam int LIMIT_W  = 32;
  localparam int CFG_A_W  = 1;
  localparam int CFG_D_W  = 32;

  localparam int IN_TDATA_W  = 72;   // channel + timestamp, padded to bytes
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 256;  // spread + three times + count, padded

  localparam int WINDOW_DEPTH_DEF = 8;

  localparam logic [FOLD_W-1:0]  FOLD_RESET  = 2'd2;
  localparam logic [FOLD_W-1:0]  FOLD_THREE  = 2'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd10000;

  // station channel codes
  localparam logic [CH_W-1:0] CH0     = 2'd0;
  localparam logic [CH_W-1:0] CH1     = 2'd1;
  localparam logic [CH_W-1:0] CH2     = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_FOLD_MODE    = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_WINDOW_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_DAT_A,
    ST_RD_B,
    ST_DAT_B,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] found_count;
    logic [TS_W-1:0]  time_third;
    logic [TS_W-1:0]  time_second;
    logic [TS_W-1:0]  time_first;
    logic [CNT_W-1:0] spread;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
  } rb_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } rb_sts_t;

endpackage

`default_nettype wire

@@ sv/tcf_result_buf.sv @@
// Result holding stage and output register; marks the final result of a run.
`default_nettype none

module tcf_result_buf (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tcf_pkg::rb_ctl_t                 ctl,
  input  wire tcf_pkg::res_t                    push_data,
  output tcf_pkg::rb_sts_t                      sts,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // spread, time_first_station, time_second_station, time_third_station,
  // found_count, zero fill
  output logic [tcf_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);

  localparam int PAD_W = tcf_pkg::OUT_TDATA_W - $bits(tcf_pkg::res_t);

  logic          pend_v_r;
  logic          pend_v_nxt;
  tcf_pkg::res_t pend_r;
  tcf_pkg::res_t pend_nxt;
  logic          out_v_r;
  logic          out_v_nxt;
  tcf_pkg::res_t out_r;
  tcf_pkg::res_t out_nxt;
  logic          last_r;
  logic          last_nxt;
  logic          out_free;

  assign out_free     = !out_v_r || out_tready;
  assign sts.push_ok  = !pend_v_r || out_free;
  assign sts.flush_ok = !pend_v_r || out_free;

  // A result is held back one step until the next one (or the end of the
  // run) shows whether it is the last.
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_nxt    = out_r;
    last_nxt   = last_r;
    if (ctl.push && sts.push_ok) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = push_data;
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
        last_nxt  = 1'b0;
      end
    end else if (ctl.flush && pend_v_r && out_free) begin
      pend_v_nxt = 1'b0;
      out_v_nxt  = 1'b1;
      out_nxt    = pend_r;
      last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

@@ sv/timestamp_coincidence_finder.sv @@
// Top level of the timestamp coincidence finder.
`default_nettype none

// Takes time-ordered detector events and reports every pair (fold modes 0 to 2) or
// triple (fold mode 3) of events from distinct channels, the new event among
// them, whose spread is strictly below window_limit. Recent event times of each
// channel live in one synchronous memory of 3 x WINDOW_DEPTH entries with a
// single read port; each kept new event is written there as it is accepted. A
// calibration event, channel 3, channel 2 in two-fold mode, or an event with an
// empty partner buffer starts no scan. Otherwise the scan reads one stored time
// per memory access, and each candidate needs a read, a distance stage and a
// compare stage; stalls on out_tready hold the scan in its compare or flush state.
// Results leave through a holding stage and an output register, at most one per
// candidate, with tlast on the last one of an event.
module timestamp_coincidence_finder #(
  parameter int WINDOW_DEPTH = tcf_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // channel, timestamp, zero fill
  input  wire logic [tcf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // calibration
  input  wire logic [tcf_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // spread, time_first_station, time_second_station, time_third_station,
  // found_count, zero fill
  output logic [tcf_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [tcf_pkg::CFG_A_W-1:0]     cfg_addr,
  input  wire logic [tcf_pkg::CFG_D_W-1:0]     cfg_wdata
);

  localparam int TS_W      = tcf_pkg::TS_W;
  localparam int CH_W      = tcf_pkg::CH_W;
  localparam int CNT_W     = tcf_pkg::CNT_W;
  localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int MEM_DEPTH = tcf_pkg::NUM_CH * WINDOW_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW_DEPTH);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0]   ch,
                                                input logic [SLOT_W-1:0] slot);
    addr_of = ADDR_W'(ch) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(slot);
  endfunction

  function automatic logic [TS_W-1:0] abs_diff(input logic [TS_W-1:0] x,
                                               input logic [TS_W-1:0] y);
    abs_diff = (x >= y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  // oldest valid slot of a ring
  function automatic logic [SLOT_W-1:0] oldest(input logic [SLOT_W-1:0] head,
                                               input logic [FILL_W-1:0] fill);
    logic [FILL_W:0] sum;
    sum = (FILL_W+1)'(head) + (FILL_W+1)'(WINDOW_DEPTH) - (FILL_W+1)'(fill);
    if (sum >= (FILL_W+1)'(WINDOW_DEPTH)) begin
      sum = sum - (FILL_W+1)'(WINDOW_DEPTH);
    end
    oldest = SLOT_W'(sum);
  endfunction

  // configuration
  logic [tcf_pkg::FOLD_W-1:0]  fold_r;
  logic [tcf_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r  <= tcf_pkg::FOLD_RESET;
      limit_r <= tcf_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tcf_pkg::CFG_FOLD_MODE:    fold_r  <= cfg_wdata[tcf_pkg::FOLD_W-1:0];
        tcf_pkg::CFG_WINDOW_LIMIT: limit_r <= cfg_wdata[tcf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [CH_W-1:0] in_ch;
  logic [TS_W-1:0] in_ts;
  logic            in_cal;
  logic            in_fire;
  logic            three_now;
  logic            keep;
  logic [CH_W-1:0] a_sel;
  logic [CH_W-1:0] b_sel;
  logic            scan;

  assign in_ch     = in_tdata[CH_W-1:0];
  assign in_ts     = in_tdata[CH_W +: TS_W];
  assign in_cal    = in_tuser[0];
  assign in_fire   = in_tvalid && in_tready;
  assign three_now = (fold_r == tcf_pkg::FOLD_THREE);
  assign keep      = !in_cal && (in_ch != tcf_pkg::CH_NONE) &&
                     (three_now || (in_ch != tcf_pkg::CH2));
  assign a_sel     = (in_ch == tcf_pkg::CH0) ? tcf_pkg::CH1 : tcf_pkg::CH0;
  assign b_sel     = !three_now ? tcf_pkg::CH2 :
                     (in_ch == tcf_pkg::CH2) ? tcf_pkg::CH1 : tcf_pkg::CH2;

  // ring pointers per channel
  logic [FILL_W-1:0] fill_r [tcf_pkg::NUM_CH];
  logic [SLOT_W-1:0] head_r [tcf_pkg::NUM_CH];

  assign scan = (fill_r[a_sel] != '0) && (!three_now || (fill_r[b_sel] != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < tcf_pkg::NUM_CH; c++) begin
        fill_r[c] <= '0;
        head_r[c] <= '0;
      end
    end else if (in_fire && keep) begin
      head_r[in_ch] <= slot_inc(head_r[in_ch]);
      if (fill_r[in_ch] != FILL_MAX) begin
        fill_r[in_ch] <= fill_r[in_ch] + FILL_W'(1);
      end
    end
  end

  // window memory
  tcf_pkg::state_t   state_r;
  tcf_pkg::state_t   state_nxt;
  logic [TS_W-1:0]   mem [MEM_DEPTH];
  logic [TS_W-1:0]   mem_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic              three_r, three_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic [CH_W-1:0]   a_r, a_nxt;
  logic [CH_W-1:0]   b_r, b_nxt;
  logic [FILL_W-1:0] fa_r, fa_nxt;
  logic [FILL_W-1:0] fb_r, fb_nxt;
  logic [FILL_W-1:0] a_idx_r, a_idx_nxt;
  logic [FILL_W-1:0] b_idx_r, b_idx_nxt;
  logic [SLOT_W-1:0] a_slot_r, a_slot_nxt;
  logic [SLOT_W-1:0] b_slot_r, b_slot_nxt;
  logic [SLOT_W-1:0] sb_r, sb_nxt;
  logic [TS_W-1:0]   ua_r, ua_nxt;
  logic [TS_W-1:0]   ub_r, ub_nxt;
  logic [TS_W-1:0]   d_ta_r, d_ta_nxt;
  logic [TS_W-1:0]   d_tb_r, d_tb_nxt;
  logic [TS_W-1:0]   d_ab_r, d_ab_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  assign mem_we  = in_fire && keep;
  assign rd_addr = (state_r == tcf_pkg::ST_RD_B) ? addr_of(b_r, b_slot_r)
                                                 : addr_of(a_r, a_slot_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_of(in_ch, head_r[in_ch])] <= in_ts;
    end
    mem_q <= mem[rd_addr];
  end

  // candidate check: spread < limit exactly when every pairwise distance is
  logic [TS_W-1:0]    lim_ext;
  logic               hit;
  logic [CNT_W-1:0]   s_ta, s_tb, s_ab, s_max1, spread;
  logic [CNT_W-1:0]   count_inc;
  logic               inner_more;
  logic               outer_more;
  tcf_pkg::res_t      res;
  tcf_pkg::rb_ctl_t   rb_ctl;
  tcf_pkg::rb_sts_t   rb_sts;

  assign lim_ext = TS_W'(limit_r);
  assign hit     = (d_ta_r < lim_ext) && (d_tb_r < lim_ext) && (d_ab_r < lim_ext);
  assign s_ta    = d_ta_r[CNT_W-1:0];
  assign s_tb    = d_tb_r[CNT_W-1:0];
  assign s_ab    = d_ab_r[CNT_W-1:0];
  assign s_max1  = (s_ta > s_tb) ? s_ta : s_tb;
  assign spread  = (s_max1 > s_ab) ? s_max1 : s_ab;

  assign count_inc  = (total_r == '1) ? total_r : total_r + CNT_W'(1);
  assign inner_more = three_r && (b_idx_r != fb_r - FILL_W'(1));
  assign outer_more = (a_idx_r != fa_r - FILL_W'(1));

  // place each member under its station
  always_comb begin
    res             = '0;
    res.spread      = spread;
    res.found_count = count_inc;
    res.time_first  = (ch_r == tcf_pkg::CH0) ? ts_r :
                      (a_r == tcf_pkg::CH0) ? ua_r : ub_r;
    res.time_second = (ch_r == tcf_pkg::CH1) ? ts_r :
                      (a_r == tcf_pkg::CH1) ? ua_r : ub_r;
    res.time_third  = (ch_r == tcf_pkg::CH2) ? ts_r :
                      (a_r == tcf_pkg::CH2) ? ua_r : ub_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcf_pkg::ST_IDLE: begin
        if (in_fire && keep && scan) begin
          state_nxt = tcf_pkg::ST_RD_A;
        end
      end
      tcf_pkg::ST_RD_A:  state_nxt = tcf_pkg::ST_DAT_A;
      tcf_pkg::ST_DAT_A: state_nxt = three_r ? tcf_pkg::ST_RD_B : tcf_pkg::ST_EVAL;
      tcf_pkg::ST_RD_B:  state_nxt = tcf_pkg::ST_DAT_B;
      tcf_pkg::ST_DAT_B: state_nxt = tcf_pkg::ST_EVAL;
      tcf_pkg::ST_EVAL: begin
        if (!hit || rb_sts.push_ok) begin
          if (inner_more) begin
            state_nxt = tcf_pkg::ST_RD_B;
          end else if (outer_more) begin
            state_nxt = tcf_pkg::ST_RD_A;
          end else begin
            state_nxt = tcf_pkg::ST_FLUSH;
          end
        end
      end
      tcf_pkg::ST_FLUSH: begin
        if (rb_sts.flush_ok) begin
          state_nxt = tcf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready    = (state_r == tcf_pkg::ST_IDLE);
    rb_ctl.push  = (state_r == tcf_pkg::ST_EVAL) && hit;
    rb_ctl.flush = (state_r == tcf_pkg::ST_FLUSH);
  end

  // scan datapath
  always_comb begin
    ch_nxt     = ch_r;
    three_nxt  = three_r;
    ts_nxt     = ts_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    fa_nxt     = fa_r;
    fb_nxt     = fb_r;
    a_idx_nxt  = a_idx_r;
    b_idx_nxt  = b_idx_r;
    a_slot_nxt = a_slot_r;
    b_slot_nxt = b_slot_r;
    sb_nxt     = sb_r;
    ua_nxt     = ua_r;
    ub_nxt     = ub_r;
    d_ta_nxt   = d_ta_r;
    d_tb_nxt   = d_tb_r;
    d_ab_nxt   = d_ab_r;
    total_nxt  = total_r;
    case (state_r)
      tcf_pkg::ST_IDLE: begin
        if (in_fire) begin
          ch_nxt     = in_ch;
          three_nxt  = three_now;
          ts_nxt     = in_ts;
          a_nxt      = a_sel;
          b_nxt      = b_sel;
          fa_nxt     = fill_r[a_sel];
          fb_nxt     = fill_r[b_sel];
          a_idx_nxt  = '0;
          a_slot_nxt = oldest(head_r[a_sel], fill_r[a_sel]);
          sb_nxt     = oldest(head_r[b_sel], fill_r[b_sel]);
        end
      end
      tcf_pkg::ST_DAT_A: begin
        ua_nxt     = mem_q;
        d_ta_nxt   = abs_diff(ts_r, mem_q);
        b_idx_nxt  = '0;
        b_slot_nxt = sb_r;
        if (!three_r) begin
          ub_nxt   = '0;
          d_tb_nxt = '0;
          d_ab_nxt = '0;
        end
      end
      tcf_pkg::ST_DAT_B: begin
        ub_nxt   = mem_q;
        d_tb_nxt = abs_diff(ts_r, mem_q);
        d_ab_nxt = abs_diff(ua_r, mem_q);
      end
      tcf_pkg::ST_EVAL: begin
        if (hit && rb_sts.push_ok) begin
          total_nxt = count_inc;
        end
        if (!hit || rb_sts.push_ok) begin
          if (inner_more) begin
            b_idx_nxt  = b_idx_r + FILL_W'(1);
            b_slot_nxt = slot_inc(b_slot_r);
          end else if (outer_more) begin
            a_idx_nxt  = a_idx_r + FILL_W'(1);
            a_slot_nxt = slot_inc(a_slot_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcf_pkg::ST_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    three_r  <= three_nxt;
    ts_r     <= ts_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    fa_r     <= fa_nxt;
    fb_r     <= fb_nxt;
    a_idx_r  <= a_idx_nxt;
    b_idx_r  <= b_idx_nxt;
    a_slot_r <= a_slot_nxt;
    b_slot_r <= b_slot_nxt;
    sb_r     <= sb_nxt;
    ua_r     <= ua_nxt;
    ub_r     <= ub_nxt;
    d_ta_r   <= d_ta_nxt;
    d_tb_r   <= d_tb_nxt;
    d_ab_r   <= d_ab_nxt;
  end

  tcf_result_buf u_rbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (rb_ctl),
    .push_data  (res),
    .sts        (rb_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ sv/tcf_checker.sv @@
// Port-level checks of the timestamp coincidence finder and their bind.
`default_nettype none

module tcf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [tcf_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tcf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);

  localparam int CNT_LO = tcf_pkg::OUT_TDATA_W - 3 - tcf_pkg::CNT_W;

  logic                      out_fire;
  logic [tcf_pkg::CNT_W-1:0] cnt;

  assign out_fire = out_tvalid && out_tready;
  assign cnt      = out_tdata[CNT_LO +: tcf_pkg::CNT_W];

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not quiet after reset");

  // back-to-back results carry consecutive counts
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire ##1 out_fire |->
      (cnt == $past(cnt) + tcf_pkg::CNT_W'(1)) || ($past(cnt) == '1))
    else $error("found_count skipped or repeated");

  // drop calibration events without a scan
  a_calib_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> in_tready)
    else $error("calibration event started a scan");

endmodule

bind timestamp_coincidence_finder tcf_checker u_tcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ tb/timestamp_coincidence_finder_tb.sv @@
// Self-checking testbench for the timestamp coincidence finder with a scoreboard class.
`timescale 1ns / 100ps

module timestamp_coincidence_finder_tb;
  import tcf_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  // idle wait after the scoreboard empties, meant to cover the worst scan of one event in three-fold mode
  localparam int DRAIN_CYCLES = 260;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam logic [FOLD_W-1:0] FOLD_PAIR_0 = 2'd0;
  localparam logic [FOLD_W-1:0] FOLD_PAIR_1 = 2'd1;
  localparam int SIDE_IN  = 0;
  localparam int SIDE_OUT = 1;

  typedef struct {
    logic [CNT_W-1:0] spread;
    logic [TS_W-1:0]  t_first;
    logic [TS_W-1:0]  t_second;
    logic [TS_W-1:0]  t_third;
    logic [CNT_W-1:0] count;
    logic             last;
  } coinc_t;

  class coinc_scoreboard;
    logic [TS_W-1:0]    times [NUM_CH][DEPTH];
    int                 fill [NUM_CH];
    int                 head [NUM_CH];
    logic [CNT_W-1:0]   total;
    logic [FOLD_W-1:0]  fold;
    logic [LIMIT_W-1:0] limit;
    coinc_t             coinc_q[$];
    int                 errors;

    function new();
      fold = FOLD_RESET;
      limit = LIMIT_RESET;
      total = '0;
      errors = 0;
      foreach (fill[c]) begin
        fill[c] = 0;
        head[c] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
      if (idx == CFG_FOLD_MODE) fold = val[FOLD_W-1:0];
      else limit = val[LIMIT_W-1:0];
    endfunction

    function int pending();
      return coinc_q.size();
    endfunction

    // k-th oldest valid time of channel c
    function logic [TS_W-1:0] oldest(int c, int k);
      return times[c][(head[c] + DEPTH - fill[c] + k) % DEPTH];
    endfunction

    function void add_coinc(logic [TS_W-1:0] t0, logic [TS_W-1:0] t1, logic [TS_W-1:0] t2,
                            logic [TS_W-1:0] spread);
      coinc_t e;
      if (total != '1) total++;
      e.spread = spread[CNT_W-1:0];
      e.t_first = t0;
      e.t_second = t1;
      e.t_third = t2;
      e.count = total;
      e.last = 1'b0;
      coinc_q = {coinc_q, e};
    endfunction

    function void note_event(logic [CH_W-1:0] ch, logic [TS_W-1:0] ts, logic cal);
      int a, b, n0;
      logic [TS_W-1:0] ua, ub, hi, lo;
      logic [TS_W-1:0] t [NUM_CH];
      n0 = coinc_q.size();
      if (cal || ch == CH_NONE || (fold != FOLD_THREE && ch == CH2)) return;
      a = (ch == CH0) ? 1 : 0;
      if (fold != FOLD_THREE) begin
        for (int k = 0; k < fill[a]; k++) begin
          ua = oldest(a, k);
          hi = (ua > ts) ? ua : ts;
          lo = (ua > ts) ? ts : ua;
          if (hi - lo < {31'd0, limit}) begin
            t[ch] = ts;
            t[a] = ua;
            t[2] = '0;
            add_coinc(t[0], t[1], t[2], hi - lo);
          end
        end
      end else begin
        b = (ch == CH2) ? 1 : 2;
        for (int i = 0; i < fill[a]; i++) begin
          ua = oldest(a, i);
          for (int j = 0; j < fill[b]; j++) begin
            ub = oldest(b, j);
            hi = ts;
            lo = ts;
            if (ua > hi) hi = ua;
            if (ua < lo) lo = ua;
            if (ub > hi) hi = ub;
            if (ub < lo) lo = ub;
            if (hi - lo < {31'd0, limit}) begin
              t[ch] = ts;
              t[a] = ua;
              t[b] = ub;
              add_coinc(t[0], t[1], t[2], hi - lo);
            end
          end
        end
      end
      if (coinc_q.size() > n0) coinc_q[coinc_q.size() - 1].last = 1'b1;
      // store the new event, overwriting the oldest one when full
      times[ch][head[ch]] = ts;
      head[ch] = (head[ch] + 1) % DEPTH;
      if (fill[ch] < DEPTH) fill[ch]++;
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
      res_t   r;
      coinc_t e;
      r = res_t'(data[$bits(res_t)-1:0]);
      if (coinc_q.size() == 0) begin
        $error("unexpected coincidence: spread %0d, found_count %0d", r.spread, r.found_count);
        errors++;
        return;
      end
      e = coinc_q.pop_front();
      compare_field("spread", 64'(e.spread), 64'(r.spread));
      compare_field("time_first_station", 64'(e.t_first), 64'(r.time_first));
      compare_field("time_second_station", 64'(e.t_second), 64'(r.time_second));
      compare_field("time_third_station", 64'(e.t_third), 64'(r.time_third));
      compare_field("found_count", 64'(e.count), 64'(r.found_count));
      compare_field("last_of_run", 64'(e.last), 64'(last));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // channel, timestamp, zero fill
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // calibration
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // spread, time_first_station, time_second_station, time_third_station,
  // found_count, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_A_W-1:0]     cfg_addr = '0;
  logic [CFG_D_W-1:0]     cfg_wdata = '0;

  coinc_scoreboard sb = new();
  int quiet [2] = '{0, 0};
  int out_hold = 0;

  timestamp_coincidence_finder #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wait cycles before the next transaction, with runs of back-to-back traffic
  function automatic int draw_gap(int side);
    if (quiet[side] > 0) begin
      quiet[side]--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet[side] = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast);
      out_hold = draw_gap(SIDE_OUT);
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_event(input logic [CH_W-1:0] ch, input logic [TS_W-1:0] ts,
                            input logic cal);
    int gap;
    gap = draw_gap(SIDE_IN);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({ts, ch});
    in_tuser <= cal;
    do @(posedge clk); while (!in_tready);
    sb.note_event(ch, ts, cal);
  endtask

  // hold off input until every coincidence is out and the scan has settled
  task automatic drain_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic run_phase(input logic [FOLD_W-1:0] fold, input logic [LIMIT_W-1:0] limit,
                           input int count, input logic [TS_W-1:0] start_ts);
    logic [TS_W-1:0] now, step, back;
    logic [CH_W-1:0] ch;
    int              r;
    drain_block();
    write_reg(CFG_FOLD_MODE, CFG_D_W'(fold));
    write_reg(CFG_WINDOW_LIMIT, limit);
    now = start_ts;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      step = '0;
      if (r < 60) step = TS_W'($urandom_range(0, 3000));
      else if (r < 85 && r >= 72) step = TS_W'($urandom_range(0, 300000));
      else if (r < 92 && r >= 85) step = TS_W'($urandom);
      else if (r >= 92) begin
        // step back in time
        back = TS_W'($urandom_range(1, 20000));
        now = (now > back) ? now - back : '0;
      end
      now = (TS_MAX - now < step) ? TS_MAX : now + step;
      r = $urandom_range(0, 99);
      if (fold == FOLD_THREE) ch = (r < 94) ? CH_W'($urandom_range(0, 2)) : CH_NONE;
      else if (r < 86) ch = CH_W'($urandom_range(0, 1));
      else ch = (r < 94) ? CH2 : CH_NONE;
      send_event(ch, now, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: pairs, window 10000
    send_event(CH0, TS_W'(0), 1'b0);
    send_event(CH1, TS_W'(5), 1'b0);
    send_event(CH1, TS_W'(10000), 1'b0);   // spread equals window: no pair
    send_event(CH0, TS_W'(10003), 1'b1);   // calibration
    send_event(CH_NONE, TS_W'(10004), 1'b0);
    send_event(CH2, TS_W'(10005), 1'b0);   // unused channel in two-fold mode
    send_event(CH0, TS_W'(10005), 1'b0);
    for (int i = 0; i < 9; i++) send_event(CH1, TS_W'(10006 + i), 1'b0);  // wrap the ring
    send_event(CH0, TS_MAX - 3, 1'b0);
    send_event(CH1, TS_MAX, 1'b0);
    send_event(CH0, TS_MAX, 1'b0);
    send_event(CH1, TS_W'(100), 1'b0);     // out of order
    send_event(CH0, TS_W'(150), 1'b0);

    run_phase(FOLD_THREE, 32'd10000, 80, TS_W'(1000));
    run_phase(FOLD_THREE, 32'd0, 20, TS_W'({$urandom, $urandom}) >> 2);
    run_phase(FOLD_RESET, 32'hFFFF_FFFF, 40, TS_W'($urandom));
    run_phase(FOLD_PAIR_1, 32'd500, 60, TS_W'({$urandom, $urandom}) >> 1);
    run_phase(FOLD_PAIR_0, 32'd1, 30, TS_W'(50));
    run_phase(FOLD_THREE, 32'hFFFF_FFFF, 50, TS_MAX - TS_W'(40000));
    run_phase(FOLD_THREE, 32'd2000, 100, TS_W'({$urandom, $urandom}) >> 3);

    drain_block();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
